/* src/tba_pkg.sv */
// Shared types and constants for the time-binned averager.
// No dependencies; every other file in src imports this package.
package tba_pkg;

  localparam int TIME_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int STATUS_W    = 16;
  localparam int AVG_W       = 16;
  localparam int BIN_INDEX_W = 9;
  localparam int LEN_W       = 12;
  localparam int COUNT_W     = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_LANES   = 8;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 12'd4095;

  localparam logic [TIME_W-1:0] WINDOW_START_RST = 32'd1651795200;
  localparam logic [LEN_W-1:0]  BIN_LENGTH_RST   = 12'd300;

  localparam int NUM_BINS_DEF       = 288;
  localparam int LANES_DEF          = 8;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int WINDOW_SECONDS_DEF = 24 * 60 * 60;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_LENGTH   = 2'd1;

  typedef struct packed {
    logic [TIME_W-1:0]   timestamp;
    logic                flush;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic [STATUS_W-1:0] status_flags;
  } item_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [TIME_W-1:0]      bin_time;
    logic [AVG_W-1:0]       avg_0;
    logic [AVG_W-1:0]       avg_1;
    logic [AVG_W-1:0]       avg_2;
    logic [AVG_W-1:0]       avg_3;
    logic [AVG_W-1:0]       avg_4;
    logic [AVG_W-1:0]       avg_5;
    logic [AVG_W-1:0]       avg_6;
    logic [AVG_W-1:0]       avg_7;
    logic [STATUS_W-1:0]    latest_status;
    logic                   last;
  } result_t;

  // Strobes from the sequencer to every lane
  typedef struct packed {
    logic load;   // snapshot the sum into the divider
    logic step;   // one quotient bit
    logic clear;  // zero the accumulator
    logic add;    // accumulate the lane sample
  } lane_cmd_t;

  // Bin details captured when a close starts
  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [TIME_W-1:0]      bin_time;
    logic [STATUS_W-1:0]    status;
    logic                   last;
  } close_meta_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX_DIV,
    ST_IDX_CHK,
    ST_AVG_DIV,
    ST_EMIT,
    ST_MOVE,
    ST_MOVE_TIME,
    ST_ACCUM,
    ST_FLUSH_CHK,
    ST_RESTART
  } state_t;

endpackage

/* src/tba_lane.sv */
// One sample lane: running sum of the bin and a bit-serial divider for its mean.
// Depends on tba_pkg.
module tba_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tba_pkg::lane_cmd_t           cmd,
  input  logic [tba_pkg::SAMPLE_W-1:0] sample,
  input  logic [tba_pkg::COUNT_W-1:0]  count,
  output logic [tba_pkg::AVG_W-1:0]    avg
);
  import tba_pkg::*;

  localparam int SUM_W    = SAMPLE_BITS + COUNT_W;
  localparam int IN_BITS  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int OUT_BITS = (SAMPLE_BITS < AVG_W) ? SAMPLE_BITS : AVG_W;

  logic [SUM_W-1:0]       sum;
  logic [COUNT_W-1:0]     rem;
  logic [SAMPLE_BITS-1:0] quo;
  logic [COUNT_W:0]       trial;
  logic                   fits;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum <= '0;
    end else if (cmd.add) begin
      sum <= sum + SUM_W'(sample[IN_BITS-1:0]);
    end
  end

  // The mean never exceeds the largest sample, so the top COUNT_W bits of the
  // sum start as the partial remainder and only SAMPLE_BITS steps are needed.
  always_comb begin
    trial = {rem, quo[SAMPLE_BITS-1]};
    fits  = trial >= {1'b0, count};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= sum[SUM_W-1:SAMPLE_BITS];
      quo <= sum[SAMPLE_BITS-1:0];
    end else if (cmd.step) begin
      rem <= fits ? COUNT_W'(trial - {1'b0, count}) : trial[COUNT_W-1:0];
      quo <= {quo[SAMPLE_BITS-2:0], fits};
    end
  end

  assign avg = AVG_W'(quo[OUT_BITS-1:0]);

endmodule

/* src/tba_idx_div.sv */
// Bin index divider: offset into the window over the bin length, one bit a cycle.
// Depends on tba_pkg.
module tba_idx_div #(
  parameter int DIFF_W = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIFF_W-1:0]         dividend,
  input  logic [tba_pkg::LEN_W-1:0] divisor,
  output logic                      busy,
  output logic [DIFF_W-1:0]         quotient
);
  import tba_pkg::*;

  localparam int CNT_W = $clog2(DIFF_W);

  logic [LEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, quotient[DIFF_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIFF_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
      quotient <= {quotient[DIFF_W-2:0], fits};
    end
  end

endmodule

/* src/tba_merge.sv */
// Merging stage: gathers the lane means and the bin details into the result
// register that faces the output channel. Depends on tba_pkg.
module tba_merge #(
  parameter int LANES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                capture,
  input  tba_pkg::close_meta_t                meta,
  input  logic [LANES-1:0][tba_pkg::AVG_W-1:0] lane_avg,
  input  logic                                emit_req,
  output logic                                loaded,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tba_pkg::result_t                    result
);
  import tba_pkg::*;

  close_meta_t                      meta_q;
  logic [MAX_LANES-1:0][AVG_W-1:0]  avg_all;
  result_t                          result_next;

  always_ff @(posedge clk) begin
    if (capture) begin
      meta_q <= meta;
    end
  end

  // lanes that are not built read as zero
  always_comb begin
    avg_all = '0;
    for (int j = 0; j < LANES; j++) begin
      avg_all[j] = lane_avg[j];
    end
  end

  always_comb begin
    result_next.bin_index     = meta_q.bin_index;
    result_next.bin_time      = meta_q.bin_time;
    result_next.avg_0         = avg_all[0];
    result_next.avg_1         = avg_all[1];
    result_next.avg_2         = avg_all[2];
    result_next.avg_3         = avg_all[3];
    result_next.avg_4         = avg_all[4];
    result_next.avg_5         = avg_all[5];
    result_next.avg_6         = avg_all[6];
    result_next.avg_7         = avg_all[7];
    result_next.latest_status = meta_q.status;
    result_next.last          = meta_q.last;
  end

  assign loaded = emit_req && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (loaded) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (loaded) begin
      result <= result_next;
    end
  end

endmodule

/* src/time_binned_averager.sv */
// Time-binned averager, top level. Depends on tba_pkg, tba_lane, tba_idx_div
// and tba_merge.
//
// Items (timestamp, flush, eight samples, status) enter on item_valid/item_stall
// and closed bins leave on result_valid/result_stall; both move an item on a
// clock edge with valid high and stall low. window_start and bin_length are
// written through cfg_write/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. A write
// to either register restarts binning at bin 0, other indexes are ignored.
// One item is worked on at a time; item_stall is high until it is done.
// An item outside the window goes straight to the flush check. An item inside
// it runs through the one-bit-a-cycle bin index divider over DIFF_W, the bits
// of the window length, then the bin check, accumulate and flush check states.
// Moving to a later bin adds the move states, and a flush the restart state.
// Each closed bin adds a pass through the lane dividers, which run side by side,
// and the result register then holds it until the receiver takes it; while the
// result register is full and stalled, the next close waits.
// Synchronous reset clears all bin state, loads the register reset values and
// empties the result register.
module time_binned_averager
  import tba_pkg::*;
#(
  parameter int NUM_BINS       = NUM_BINS_DEF,
  parameter int LANES          = LANES_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int WINDOW_SECONDS = WINDOW_SECONDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIFF_W    = $clog2(WINDOW_SECONDS + 1);
  localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int PROD_W    = BIN_W + LEN_W;
  localparam int AVG_CNT_W = $clog2(SAMPLE_BITS);

  state_t state, state_next;

  logic [TIME_W-1:0]    window_start;
  logic [LEN_W-1:0]     bin_length;
  logic [LEN_W-1:0]     len_eff;
  item_t                item_q;
  logic [COUNT_W-1:0]   count;
  logic [BIN_W-1:0]     cur_bin;
  logic [BIN_W-1:0]     idx_q;
  logic [BIN_W-1:0]     idx_sat;
  logic [TIME_W-1:0]    bin_start;
  logic [STATUS_W-1:0]  held_status;
  logic [PROD_W-1:0]    prod;
  logic                 close_last;
  logic [AVG_CNT_W-1:0] avg_cnt;

  logic                 accept;
  logic                 cfg_hit;
  logic [TIME_W:0]      diff;
  logic                 in_window;
  logic                 div_start;
  logic                 div_busy;
  logic [DIFF_W-1:0]    div_quo;
  logic                 close_start;
  logic                 emit_req;
  logic                 loaded;
  logic                 not_full;
  lane_cmd_t            lane_cmd;
  close_meta_t          meta;

  logic [MAX_LANES-1:0][SAMPLE_W-1:0] samples;
  logic [LANES-1:0][AVG_W-1:0]        lane_avg;

  assign len_eff  = (bin_length == '0) ? LEN_W'(1) : bin_length;
  assign accept   = item_valid && !item_stall;
  assign not_full = count < MAX_COUNT;

  // only writes to a known register restart binning
  assign cfg_hit = cfg_write &&
                   ((cfg_index == REG_WINDOW_START) || (cfg_index == REG_BIN_LENGTH));

  assign diff      = {1'b0, item.timestamp} - {1'b0, window_start};
  assign in_window = !diff[TIME_W] && (diff <= (TIME_W + 1)'(WINDOW_SECONDS));

  always_comb begin
    if (32'(div_quo) >= 32'(NUM_BINS)) begin
      idx_sat = BIN_W'(NUM_BINS - 1);
    end else begin
      idx_sat = BIN_W'(div_quo);
    end
  end

  always_comb begin
    samples[0] = item_q.sample_0;
    samples[1] = item_q.sample_1;
    samples[2] = item_q.sample_2;
    samples[3] = item_q.sample_3;
    samples[4] = item_q.sample_4;
    samples[5] = item_q.sample_5;
    samples[6] = item_q.sample_6;
    samples[7] = item_q.sample_7;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = in_window ? ST_IDX_DIV : ST_FLUSH_CHK;
        end
      end
      ST_IDX_DIV: begin
        if (!div_busy) begin
          state_next = ST_IDX_CHK;
        end
      end
      ST_IDX_CHK: begin
        if (idx_sat > cur_bin) begin
          state_next = (count != '0) ? ST_AVG_DIV : ST_MOVE;
        end else begin
          state_next = ST_ACCUM;
        end
      end
      ST_AVG_DIV: begin
        if (avg_cnt == AVG_CNT_W'(SAMPLE_BITS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (loaded) begin
          state_next = close_last ? ST_RESTART : ST_MOVE;
        end
      end
      ST_MOVE:      state_next = ST_MOVE_TIME;
      ST_MOVE_TIME: state_next = ST_ACCUM;
      ST_ACCUM:     state_next = ST_FLUSH_CHK;
      ST_FLUSH_CHK: begin
        if (item_q.flush) begin
          state_next = (count != '0) ? ST_AVG_DIV : ST_RESTART;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RESTART:   state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    item_stall     = 1'b1;
    div_start      = 1'b0;
    close_start    = 1'b0;
    emit_req       = 1'b0;
    lane_cmd       = '0;
    lane_cmd.clear = cfg_hit;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        div_start  = item_valid && in_window;
      end
      ST_IDX_CHK: begin
        close_start   = (idx_sat > cur_bin) && (count != '0);
        lane_cmd.load = close_start;
      end
      ST_AVG_DIV:   lane_cmd.step = 1'b1;
      ST_EMIT:      emit_req = 1'b1;
      ST_MOVE:      lane_cmd.clear = 1'b1;
      ST_ACCUM:     lane_cmd.add = not_full;
      ST_FLUSH_CHK: begin
        close_start   = item_q.flush && (count != '0);
        lane_cmd.load = close_start;
      end
      ST_RESTART:   lane_cmd.clear = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    meta.bin_index = BIN_INDEX_W'(cur_bin);
    meta.bin_time  = bin_start;
    meta.status    = held_status;
    meta.last      = (state == ST_FLUSH_CHK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= WINDOW_START_RST;
      bin_length   <= BIN_LENGTH_RST;
      count        <= '0;
      cur_bin      <= '0;
      bin_start    <= WINDOW_START_RST;
      held_status  <= '0;
      close_last   <= 1'b0;
      avg_cnt      <= '0;
    end else if (cfg_hit) begin
      count       <= '0;
      cur_bin     <= '0;
      held_status <= '0;
      bin_start   <= window_start;
      if (cfg_index == REG_WINDOW_START) begin
        window_start <= cfg_data;
        bin_start    <= cfg_data;
      end else if (cfg_index == REG_BIN_LENGTH) begin
        bin_length <= cfg_data[LEN_W-1:0];
      end
    end else begin
      if (close_start) begin
        close_last <= meta.last;
        avg_cnt    <= '0;
      end
      case (state)
        ST_AVG_DIV: avg_cnt <= avg_cnt + AVG_CNT_W'(1);
        ST_MOVE: begin
          count       <= '0;
          held_status <= '0;
          cur_bin     <= idx_q;
        end
        ST_MOVE_TIME: bin_start <= window_start + TIME_W'(prod);
        ST_ACCUM: begin
          if (not_full) begin
            count       <= count + COUNT_W'(1);
            held_status <= item_q.status_flags;
          end
        end
        ST_RESTART: begin
          count       <= '0;
          cur_bin     <= '0;
          held_status <= '0;
          bin_start   <= window_start;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == ST_IDX_CHK) begin
      idx_q <= idx_sat;
    end
    if (state == ST_MOVE) begin
      prod <= PROD_W'(idx_q) * PROD_W'(len_eff);
    end
  end

  tba_idx_div #(
    .DIFF_W(DIFF_W)
  ) u_idx_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff[DIFF_W-1:0]),
    .divisor  (len_eff),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tba_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (lane_cmd),
      .sample (samples[g]),
      .count  (count),
      .avg    (lane_avg[g])
    );
  end

  tba_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .capture      (close_start),
    .meta         (meta),
    .lane_avg     (lane_avg),
    .emit_req     (emit_req),
    .loaded       (loaded),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* verif/tb_top.sv */
// Testbench for time_binned_averager: randomised record streams under several
// register settings, checked bin by bin against an in-bench model of the averager.
// Depends on tba_pkg and the time_binned_averager RTL.
`timescale 1ns / 100ps

module tb_top;
  import tba_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  time_binned_averager u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench copy of the averager state
  logic [TIME_W-1:0]      p_win_start;
  logic [LEN_W-1:0]       p_bin_len;
  logic [27:0]            acc_sum [MAX_LANES];
  logic [COUNT_W-1:0]     acc_count;
  logic [BIN_INDEX_W-1:0] acc_bin;
  logic [TIME_W-1:0]      acc_bin_time;
  logic [STATUS_W-1:0]    acc_status;

  item_t   pending_records [$];
  result_t exp_bins [$];

  int  queued_total = 0;
  int  taken_total = 0;
  int  bins_checked = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  item_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  function automatic void restart_bins();
    foreach (acc_sum[j]) acc_sum[j] = '0;
    acc_count    = '0;
    acc_bin      = '0;
    acc_status   = '0;
    acc_bin_time = p_win_start;
  endfunction

  function automatic void close_bin(input logic fin);
    result_t r;
    logic [AVG_W-1:0] av [MAX_LANES];
    foreach (av[j]) av[j] = 16'(acc_sum[j] / acc_count);
    r.bin_index     = acc_bin;
    r.bin_time      = acc_bin_time;
    r.avg_0         = av[0];
    r.avg_1         = av[1];
    r.avg_2         = av[2];
    r.avg_3         = av[3];
    r.avg_4         = av[4];
    r.avg_5         = av[5];
    r.avg_6         = av[6];
    r.avg_7         = av[7];
    r.latest_status = acc_status;
    r.last          = fin;
    exp_bins.push_back(r);
  endfunction

  // Folds one record into the open bin, closing bins as the model dictates
  function automatic void bin_record(input item_t it);
    logic [SAMPLE_W-1:0] smp [MAX_LANES];
    longint unsigned ts, ws, eff, idx;
    smp = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
            it.sample_4, it.sample_5, it.sample_6, it.sample_7};
    ts  = it.timestamp;
    ws  = p_win_start;
    eff = (p_bin_len == 0) ? 1 : p_bin_len;
    if (ts >= ws && ts <= ws + WINDOW_SECONDS_DEF) begin
      idx = (ts - ws) / eff;
      if (idx >= NUM_BINS_DEF) idx = NUM_BINS_DEF - 1;
      if (idx > acc_bin) begin
        if (acc_count != 0) close_bin(1'b0);
        foreach (acc_sum[j]) acc_sum[j] = '0;
        acc_count    = '0;
        acc_status   = '0;
        acc_bin      = 9'(idx);
        acc_bin_time = 32'(ws + idx * eff);
      end
      if (acc_count < MAX_COUNT) begin
        foreach (acc_sum[j]) acc_sum[j] = acc_sum[j] + smp[j];
        acc_count  = acc_count + 1'b1;
        acc_status = it.status_flags;
      end
    end
    if (it.flush) begin
      if (acc_count != 0) close_bin(1'b1);
      restart_bins();
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    else if (r == 1) return '1;
    else return 16'($urandom());
  endfunction

  function automatic item_t make_record(input logic [TIME_W-1:0] ts, input logic fl);
    item_t it;
    it.timestamp    = ts;
    it.flush        = fl;
    it.sample_0     = rand_sample();
    it.sample_1     = rand_sample();
    it.sample_2     = rand_sample();
    it.sample_3     = rand_sample();
    it.sample_4     = rand_sample();
    it.sample_5     = rand_sample();
    it.sample_6     = rand_sample();
    it.sample_7     = rand_sample();
    it.status_flags = 16'($urandom());
    return it;
  endfunction

  function automatic void push_item(input item_t it);
    pending_records.push_back(it);
    queued_total++;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Register writes only happen with the block idle, so the model follows at once
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_WINDOW_START) begin
      p_win_start = data;
      restart_bins();
    end else if (idx == REG_BIN_LENGTH) begin
      p_bin_len = data[LEN_W-1:0];
      restart_bins();
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for every queued record to be taken and every bin to come back,
  // then allow for a record still in flight that closes nothing
  task automatic drain();
    while (taken_total != queued_total || exp_bins.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly ordered records with random gaps; some jumps over bins, some
  // late or stray timestamps, and the odd flush
  task automatic queue_stream(input int n);
    longint unsigned ws, lim, cur, back;
    int unsigned len, r;
    logic [TIME_W-1:0] ts;
    logic fl;
    ws  = p_win_start;
    len = (p_bin_len == 0) ? 1 : p_bin_len;
    lim = ws + WINDOW_SECONDS_DEF;
    cur = ws;
    repeat (n) begin
      r  = $urandom_range(99);
      fl = ($urandom_range(99) < 3);
      if (r < 4) begin
        ts = $urandom();
      end else if (r < 9) begin
        back = $urandom_range(0, 2 * len);
        ts   = (cur > back) ? 32'(cur - back) : 32'd0;
      end else begin
        cur += (r < 21) ? $urandom_range(len, 8 * len) : $urandom_range(0, len / 3);
        if (cur > lim || cur > 64'hFFFF_FFFF) begin
          ts = (cur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(cur);
          fl = 1'b1;
        end else begin
          ts = 32'(cur);
        end
      end
      push_item(make_record(ts, fl));
      if (fl) cur = ws + $urandom_range(0, len);
    end
  endtask

  // Sender
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_records.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= pending_records.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        bin_record(item);
        taken_total++;
      end
      if (result_valid && !result_stall) begin
        if (exp_bins.size() == 0) begin
          $error("bin %0d emitted with none expected", result.bin_index);
          mismatches++;
        end else begin
          want = exp_bins.pop_front();
          check_field("bin_index", want.bin_index, result.bin_index);
          check_field("bin_time", want.bin_time, result.bin_time);
          check_field("avg_0", want.avg_0, result.avg_0);
          check_field("avg_1", want.avg_1, result.avg_1);
          check_field("avg_2", want.avg_2, result.avg_2);
          check_field("avg_3", want.avg_3, result.avg_3);
          check_field("avg_4", want.avg_4, result.avg_4);
          check_field("avg_5", want.avg_5, result.avg_5);
          check_field("avg_6", want.avg_6, result.avg_6);
          check_field("avg_7", want.avg_7, result.avg_7);
          check_field("latest_status", want.latest_status, result.latest_status);
          check_field("last", want.last, result.last);
          bins_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bins outstanding", cycle_count, exp_bins.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    item_t it;
    logic [TIME_W-1:0] w;
    p_win_start = WINDOW_START_RST;
    p_bin_len   = BIN_LENGTH_RST;
    restart_bins();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed records on the reset settings
    send_idle_pct = 33;
    recv_idle_pct = 57;
    w = WINDOW_START_RST;
    push_item(make_record(w - 1, 1'b0));            // just before the window
    it = make_record(w, 1'b0);
    {it.sample_0, it.sample_1, it.sample_2, it.sample_3,
     it.sample_4, it.sample_5, it.sample_6, it.sample_7} = {8{16'hFFFF}};
    it.status_flags = 16'hFFFF;
    push_item(it);
    it = make_record(w + 299, 1'b0);
    {it.sample_0, it.sample_1, it.sample_2, it.sample_3,
     it.sample_4, it.sample_5, it.sample_6, it.sample_7} = '0;
    it.status_flags = 16'h0000;
    push_item(it);
    push_item(make_record(w + 300, 1'b0));          // closes bin 0
    push_item(make_record(w + 100, 1'b0));          // late record, stays in bin 1
    push_item(make_record(w + 3000, 1'b0));         // skips empty bins
    push_item(make_record(w + WINDOW_SECONDS_DEF, 1'b0));      // window end, last bin
    push_item(make_record(w + WINDOW_SECONDS_DEF + 1, 1'b1));  // stray flush still closes
    push_item(make_record(w + WINDOW_SECONDS_DEF + 1, 1'b1));  // flush on empty bin
    push_item(make_record(w + 600, 1'b1));
    push_item(make_record(w + 10, 1'b0));
    push_item(make_record(w + 700, 1'b1));          // normal close then flush close
    push_item(make_record(32'hFFFF_FFFF, 1'b0));
    push_item(make_record(32'h0000_0000, 1'b0));
    push_item(make_record(w + 5, 1'b0));
    queue_stream(500);
    drain();

    // One-second bins from time zero
    write_reg(REG_WINDOW_START, 32'h0000_0000);
    write_reg(REG_BIN_LENGTH, 32'd1);
    queue_stream(300);
    drain();

    // Window at the top of the time range, longest bins
    send_idle_pct = 57;
    recv_idle_pct = 33;
    write_reg(REG_WINDOW_START, 32'hFFFF_FFFF);
    write_reg(REG_BIN_LENGTH, 32'd4095);
    push_item(make_record(32'hFFFF_FFFE, 1'b0));
    push_item(make_record(32'hFFFF_FFFF, 1'b0));
    push_item(make_record(32'hFFFF_FFFF, 1'b0));
    push_item(make_record(32'hFFFF_FFFF, 1'b1));
    push_item(make_record(32'h0000_0000, 1'b1));
    drain();

    // Zero bin length (high data bits dropped), window cut off by the time range
    write_reg(REG_WINDOW_START, 32'hFFFF_0000);
    write_reg(REG_BIN_LENGTH, 32'hFFFF_F000);
    queue_stream(250);
    drain();
    // writes to unused indexes must leave the open bin alone
    write_reg(REG_SPARE_2, $urandom());
    write_reg(REG_SPARE_3, $urandom());
    queue_stream(250);
    drain();

    // Short bins with the output held off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_WINDOW_START, $urandom_range(0, 32'hFFF0_0000));
    write_reg(REG_BIN_LENGTH, 32'd7);
    hold_req = 1'b1;
    queue_stream(300);
    drain();

    $display("Checked %0d closed bins from %0d records across window, bin length",
             bins_checked, taken_total);
    $display("and flush cases, with a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
